// ===== rtl/core/ffr_pkg.sv =====
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the frame filter / reassembly receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ffr_pkg;

  // Header layout and match constants
  localparam logic [4:0]  HDR_BYTES   = 5'd24;
  localparam logic [4:0]  POS_SRC     = 5'd6;
  localparam logic [4:0]  POS_TYPE_HI = 5'd12;
  localparam logic [4:0]  POS_TYPE_LO = 5'd13;
  localparam logic [4:0]  POS_SIZE_LO = 5'd18;
  localparam logic [4:0]  POS_SIZE_HI = 5'd19;
  localparam logic [4:0]  POS_NUM_LO  = 5'd20;
  localparam logic [4:0]  POS_NUM_HI  = 5'd21;
  localparam logic [4:0]  POS_FLAGS   = 5'd22;
  localparam logic [4:0]  POS_LAST    = 5'd23;
  localparam logic [15:0] FRAME_TYPE  = 16'hCAB2;
  localparam logic [7:0]  BCAST_BYTE  = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_HOST_ADDR   = 2'd0;
  localparam logic [1:0] CFG_DEVICE_ADDR = 2'd1;
  localparam logic [1:0] CFG_ANY_SOURCE  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DELIVER = 3'd1,
    ACT_HOLD    = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_DISCARD = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_DELIVERED  = 3'd0,
    ST_HELD       = 3'd1,
    ST_SHORT      = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_BAD_DEST   = 3'd4,
    ST_BAD_SOURCE = 3'd5,
    ST_SEQUENCE   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] out_byte;
    logic       frame_done;
    status_t    frame_status;
  } out_item_t;

  typedef struct packed {
    logic [47:0] host_address;
    logic [47:0] device_address;
    logic        accept_any_source;
  } cfg_t;

  // Byte idx of a 48-bit address, byte 0 most significant
  function automatic logic [7:0] addr_byte(input logic [47:0] addr, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = addr[47:40];
      3'd1:    b = addr[39:32];
      3'd2:    b = addr[31:24];
      3'd3:    b = addr[23:16];
      3'd4:    b = addr[15:8];
      3'd5:    b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/frame_filter_reassembly_rx.sv =====
// The block takes one frame byte per item and returns one result item per
// input item, in the cycle after acceptance, from a single output register. A new
// item is taken every cycle while the output register is empty or being
// drained; a held-up result stalls the input in the same cycle. There is no
// start-up pass: items are taken straight after reset.
// ----------------------------------------------------------------------------
// frame_filter_reassembly_rx
// Receive-side frame filter with piece reassembly control: parses the
// 24-byte header, checks type, destination and source, and steers payload
// bytes to deliver, hold, release or discard.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_filter_reassembly_rx import ffr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  cfg_t      cfg_r;
  logic      item_acc;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOST_ADDR:   cfg_r.host_address      <= cfg_wdata;
        CFG_DEVICE_ADDR: cfg_r.device_address    <= cfg_wdata;
        CFG_ANY_SOURCE:  cfg_r.accept_any_source <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Input side: stall only while a result waits and is not taken
  assign in_stall = out_valid_r && out_stall;
  assign item_acc = in_valid && !in_stall;

  ffr_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .item     (in_data),
    .cfg      (cfg_r),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/ffr_step.sv =====
// ----------------------------------------------------------------------------
// ffr_step
// Per-byte header parser, frame filter and piece sequencer. Produces the
// result for the current item combinationally and updates frame state on
// acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module ffr_step import ffr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_acc,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      res
);

  logic [4:0]  hdr_pos_r,    hdr_pos_nxt;
  logic        dst_match_r,  dst_match_nxt;
  logic        dst_bcast_r,  dst_bcast_nxt;
  logic        src_match_r,  src_match_nxt;
  logic [15:0] type_r,       type_nxt;
  logic [15:0] size_r,       size_nxt;
  logic [15:0] piece_num_r,  piece_num_nxt;
  logic [1:0]  flags_r,      flags_nxt;
  logic [15:0] pay_cnt_r,    pay_cnt_nxt;
  status_t     class_r,      class_nxt;
  logic        reasm_act_r,  reasm_act_nxt;
  logic [15:0] reasm_num_r,  reasm_num_nxt;

  logic [4:0]  src_off;
  logic        first_p;
  logic        last_p;
  action_t     act;
  status_t     status;
  logic [7:0]  obyte;

  assign src_off = hdr_pos_r - POS_SRC;
  assign first_p = flags_r[0];
  assign last_p  = flags_r[1];

  // Next state and result for the current item
  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    dst_match_nxt = dst_match_r;
    dst_bcast_nxt = dst_bcast_r;
    src_match_nxt = src_match_r;
    type_nxt      = type_r;
    size_nxt      = size_r;
    piece_num_nxt = piece_num_r;
    flags_nxt     = flags_r;
    pay_cnt_nxt   = pay_cnt_r;
    class_nxt     = class_r;
    reasm_act_nxt = reasm_act_r;
    reasm_num_nxt = reasm_num_r;
    act           = ACT_NONE;
    obyte         = 8'h00;
    status        = ST_DELIVERED;

    if (hdr_pos_r < HDR_BYTES) begin
      // header field capture
      if (hdr_pos_r < POS_SRC) begin
        if (item.in_byte != addr_byte(cfg.host_address, hdr_pos_r[2:0])) dst_match_nxt = 1'b0;
        if (item.in_byte != BCAST_BYTE) dst_bcast_nxt = 1'b0;
      end else if (hdr_pos_r < POS_TYPE_HI) begin
        if (item.in_byte != addr_byte(cfg.device_address, src_off[2:0])) src_match_nxt = 1'b0;
      end else begin
        case (hdr_pos_r)
          POS_TYPE_HI: type_nxt      = {item.in_byte, type_r[7:0]};
          POS_TYPE_LO: type_nxt      = {type_r[15:8], item.in_byte};
          POS_SIZE_LO: size_nxt      = {size_r[15:8], item.in_byte};
          POS_SIZE_HI: size_nxt      = {item.in_byte, size_r[7:0]};
          POS_NUM_LO:  piece_num_nxt = {piece_num_r[15:8], item.in_byte};
          POS_NUM_HI:  piece_num_nxt = {item.in_byte, piece_num_r[7:0]};
          POS_FLAGS:   flags_nxt     = item.in_byte[1:0];
          default:     ;
        endcase
      end
      hdr_pos_nxt = hdr_pos_r + 5'd1;

      // frame decision at the last header byte
      if (hdr_pos_r == POS_LAST) begin
        if (type_r != FRAME_TYPE) begin
          class_nxt = ST_BAD_TYPE;
        end else if (!dst_match_r && !dst_bcast_r) begin
          class_nxt = ST_BAD_DEST;
        end else if (!cfg.accept_any_source && !src_match_r) begin
          class_nxt = ST_BAD_SOURCE;
        end else if (first_p && last_p) begin
          class_nxt = ST_DELIVERED;
        end else if (first_p) begin
          if (reasm_act_r) act = ACT_DISCARD;
          reasm_act_nxt = 1'b1;
          reasm_num_nxt = piece_num_r;
          class_nxt     = ST_HELD;
        end else if (!reasm_act_r || reasm_num_r != piece_num_r) begin
          reasm_act_nxt = 1'b0;
          act           = ACT_DISCARD;
          class_nxt     = ST_SEQUENCE;
        end else if (last_p) begin
          reasm_act_nxt = 1'b0;
          act           = ACT_RELEASE;
          class_nxt     = ST_DELIVERED;
        end else begin
          class_nxt = ST_HELD;
        end
      end
    end else if (pay_cnt_r < size_r) begin
      // payload within declared size
      if (class_r == ST_DELIVERED) begin
        act   = ACT_DELIVER;
        obyte = item.in_byte;
      end else if (class_r == ST_HELD) begin
        act   = ACT_HOLD;
        obyte = item.in_byte;
      end
      pay_cnt_nxt = pay_cnt_r + 16'd1;
    end

    // frame end: report and clear per-frame state
    if (item.frame_end) begin
      status        = (hdr_pos_nxt < HDR_BYTES) ? ST_SHORT : class_nxt;
      hdr_pos_nxt   = 5'd0;
      dst_match_nxt = 1'b1;
      dst_bcast_nxt = 1'b1;
      src_match_nxt = 1'b1;
      type_nxt      = 16'h0000;
      size_nxt      = 16'h0000;
      piece_num_nxt = 16'h0000;
      flags_nxt     = 2'b00;
      pay_cnt_nxt   = 16'h0000;
      class_nxt     = ST_DELIVERED;
    end
  end

  assign res.action       = act;
  assign res.out_byte     = obyte;
  assign res.frame_done   = item.frame_end;
  assign res.frame_status = status;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= 5'd0;
      dst_match_r <= 1'b1;
      dst_bcast_r <= 1'b1;
      src_match_r <= 1'b1;
      type_r      <= 16'h0000;
      size_r      <= 16'h0000;
      piece_num_r <= 16'h0000;
      flags_r     <= 2'b00;
      pay_cnt_r   <= 16'h0000;
      class_r     <= ST_DELIVERED;
      reasm_act_r <= 1'b0;
      reasm_num_r <= 16'h0000;
    end else if (item_acc) begin
      hdr_pos_r   <= hdr_pos_nxt;
      dst_match_r <= dst_match_nxt;
      dst_bcast_r <= dst_bcast_nxt;
      src_match_r <= src_match_nxt;
      type_r      <= type_nxt;
      size_r      <= size_nxt;
      piece_num_r <= piece_num_nxt;
      flags_r     <= flags_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      class_r     <= class_nxt;
      reasm_act_r <= reasm_act_nxt;
      reasm_num_r <= reasm_num_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_filter_reassembly_rx. Frames are built byte by
// byte from header fields, pushed through the valid/stall input channel under
// random idling, and every result item is compared with a cycle-free
// prediction of the filter and reassembly rules.
// ----------------------------------------------------------------------------

module tb import ffr_pkg::*;;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 80;
  localparam logic [47:0] BCAST48     = {6{BCAST_BYTE}};

  // Prediction of the steering result for each accepted byte, plus checking
  class frame_steer_check;
    logic [47:0] own_addr;
    logic [47:0] peer_addr;
    logic        any_src;
    logic [4:0]  hdr_pos;
    logic        dst_match;
    logic        dst_bcast;
    logic        src_match;
    logic [15:0] ether_type;
    logic [15:0] decl_size;
    logic [15:0] piece_num;
    logic [1:0]  piece_flags;
    logic [15:0] pay_count;
    status_t     cls;
    logic        reasm_open;
    logic [15:0] reasm_num;
    out_item_t   predicted[$];
    int          mismatches;

    function new();
      own_addr   = '0;
      peer_addr  = '0;
      any_src    = 1'b0;
      reasm_open = 1'b0;
      reasm_num  = '0;
      mismatches = 0;
      clear_frame();
    endfunction

    // Per-frame state returns here after every frame end
    function void clear_frame();
      hdr_pos     = '0;
      dst_match   = 1'b1;
      dst_bcast   = 1'b1;
      src_match   = 1'b1;
      ether_type  = '0;
      decl_size   = '0;
      piece_num   = '0;
      piece_flags = '0;
      pay_count   = '0;
      cls         = ST_DELIVERED;
    endfunction

    function void set_reg(logic [1:0] idx, logic [47:0] d);
      case (idx)
        CFG_HOST_ADDR:   own_addr = d;
        CFG_DEVICE_ADDR: peer_addr = d;
        CFG_ANY_SOURCE:  any_src = d[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void predict_byte(in_item_t it);
      out_item_t r;
      logic [7:0] b;
      int p;
      b = it.in_byte;
      p = hdr_pos;
      r.action       = ACT_NONE;
      r.out_byte     = '0;
      r.frame_done   = 1'b0;
      r.frame_status = ST_DELIVERED;
      if (hdr_pos < HDR_BYTES) begin
        // header parse: addresses MSB first, type big endian, rest little endian
        if (hdr_pos < POS_SRC) begin
          if (b != own_addr[47 - 8*p -: 8]) dst_match = 1'b0;
          if (b != BCAST_BYTE) dst_bcast = 1'b0;
        end else if (hdr_pos < POS_TYPE_HI) begin
          if (b != peer_addr[47 - 8*(p - POS_SRC) -: 8]) src_match = 1'b0;
        end else begin
          case (hdr_pos)
            POS_TYPE_HI: ether_type[15:8] = b;
            POS_TYPE_LO: ether_type[7:0]  = b;
            POS_SIZE_LO: decl_size[7:0]   = b;
            POS_SIZE_HI: decl_size[15:8]  = b;
            POS_NUM_LO:  piece_num[7:0]   = b;
            POS_NUM_HI:  piece_num[15:8]  = b;
            POS_FLAGS:   piece_flags      = b[1:0];
            default: ;
          endcase
        end
        hdr_pos = hdr_pos + 5'd1;
        // header end: filter first, then piece rules
        if (p == POS_LAST) begin
          if (ether_type != FRAME_TYPE) begin
            cls = ST_BAD_TYPE;
          end else if (!dst_match && !dst_bcast) begin
            cls = ST_BAD_DEST;
          end else if (!any_src && !src_match) begin
            cls = ST_BAD_SOURCE;
          end else if (piece_flags[0] && piece_flags[1]) begin
            cls = ST_DELIVERED;
          end else if (piece_flags[0]) begin
            if (reasm_open) r.action = ACT_DISCARD;
            reasm_open = 1'b1;
            reasm_num  = piece_num;
            cls        = ST_HELD;
          end else if (!reasm_open || reasm_num != piece_num) begin
            reasm_open = 1'b0;
            r.action   = ACT_DISCARD;
            cls        = ST_SEQUENCE;
          end else if (piece_flags[1]) begin
            reasm_open = 1'b0;
            r.action   = ACT_RELEASE;
            cls        = ST_DELIVERED;
          end else begin
            cls = ST_HELD;
          end
        end
      end else if (pay_count < decl_size) begin
        // payload, cut at the declared size
        if (cls == ST_DELIVERED) begin
          r.action   = ACT_DELIVER;
          r.out_byte = b;
        end else if (cls == ST_HELD) begin
          r.action   = ACT_HOLD;
          r.out_byte = b;
        end
        pay_count = pay_count + 16'd1;
      end
      if (it.frame_end) begin
        r.frame_done   = 1'b1;
        r.frame_status = (hdr_pos < HDR_BYTES) ? ST_SHORT : cls;
        clear_frame();
      end
      predicted.insert(predicted.size(), r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (predicted.size() == 0) begin
        $error("result item %h with nothing outstanding", got);
        mismatches++;
        return;
      end
      want = predicted.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        mismatches++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
        mismatches++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  frame_steer_check steer_chk = new();

  logic [47:0] host_addr;
  logic [47:0] dev_addr;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int          sent_items   = 0;
  int          hold_asked   = 0;
  int          hold_given   = 0;
  int          hold_left    = 0;
  int          cycle_count  = 0;

  frame_filter_reassembly_rx uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) steer_chk.set_reg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) steer_chk.check_result(out_data);
      if (in_valid && !in_stall) steer_chk.predict_byte(in_data);
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_stall  <= 1'b1;
      hold_given <= hold_given + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Mostly own or broadcast; otherwise one bit off or anything
  function automatic logic [47:0] pick_dst(input bit clean);
    int r;
    r = $urandom_range(99);
    if (clean || r < 80) return chance(60) ? host_addr : BCAST48;
    if (r < 90) return (chance(50) ? host_addr : BCAST48) ^ (48'd1 << $urandom_range(47));
    return rand48();
  endfunction

  function automatic logic [47:0] pick_src(input bit clean);
    int r;
    r = $urandom_range(99);
    if (clean || r < 80) return dev_addr;
    if (r < 90) return dev_addr ^ (48'd1 << $urandom_range(47));
    return rand48();
  endfunction

  function automatic logic [15:0] pick_type(input bit clean);
    int r;
    r = $urandom_range(99);
    if (clean || r < 85) return FRAME_TYPE;
    if (r < 93) return FRAME_TYPE ^ (16'd1 << $urandom_range(15));
    return 16'($urandom);
  endfunction

  // One item on the input channel, with a random gap ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Build a frame from its header fields; cut > 0 ends it early
  task automatic send_frame(input logic [47:0] dst, input logic [47:0] src,
                            input logic [15:0] etype, input logic [15:0] size,
                            input logic [15:0] num, input logic [1:0] flags,
                            input int pay_len, input int cut);
    logic [7:0] fb[$];
    logic [7:0] flag_byte;
    in_item_t it;
    int n;
    for (int i = 0; i < 6; i++) fb.insert(fb.size(), dst[47 - 8*i -: 8]);
    for (int i = 0; i < 6; i++) fb.insert(fb.size(), src[47 - 8*i -: 8]);
    fb.insert(fb.size(), etype[15:8]);
    fb.insert(fb.size(), etype[7:0]);
    repeat (4) fb.insert(fb.size(), 8'($urandom));
    fb.insert(fb.size(), size[7:0]);
    fb.insert(fb.size(), size[15:8]);
    fb.insert(fb.size(), num[7:0]);
    fb.insert(fb.size(), num[15:8]);
    flag_byte = 8'($urandom);
    flag_byte[1:0] = flags;
    fb.insert(fb.size(), flag_byte);
    fb.insert(fb.size(), 8'($urandom));
    repeat (pay_len) fb.insert(fb.size(), 8'($urandom));
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) begin
      it.in_byte   = fb[i];
      it.frame_end = (i == n - 1);
      send_item(it);
    end
  endtask

  // A piece with a small payload that may fall short of or overrun its size
  task automatic send_piece(input bit clean, input logic [15:0] num,
                            input logic [1:0] flags);
    logic [15:0] size;
    int pay_len;
    int r;
    r = $urandom_range(99);
    if (r < 90) begin
      size = 16'($urandom_range(0, 8));
      r = $urandom_range(99);
      if (r < 70) pay_len = size;
      else if (r < 85) pay_len = $urandom_range(0, size);
      else pay_len = size + $urandom_range(1, 4);
    end else begin
      size = 16'($urandom);
      pay_len = $urandom_range(0, 10);
    end
    send_frame(pick_dst(clean), pick_src(clean), pick_type(clean), size, num, flags,
               pay_len, 0);
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (steer_chk.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] d);
    cfg_index <= idx;
    cfg_wdata <= d;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [47:0] h, input logic [47:0] d, input logic a);
    host_addr = h;
    dev_addr  = d;
    write_reg(CFG_HOST_ADDR, h);
    write_reg(CFG_DEVICE_ADDR, d);
    write_reg(CFG_ANY_SOURCE, {47'd0, a});
  endtask

  // Random traffic: reassembly runs of first, middle and last pieces, mixed with single pieces and noise
  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    logic [15:0] num;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      num  = 16'($urandom);
      if (pick < 45) begin
        send_piece(chance(90), num, 2'b01);
        repeat ($urandom_range(0, 3)) send_piece(chance(90), chance(92) ? num : 16'($urandom),
                                                 2'b00);
        send_piece(chance(90), chance(92) ? num : num ^ (16'd1 << $urandom_range(15)), 2'b10);
      end else if (pick < 65) begin
        send_piece(chance(80), num, 2'b11);
      end else if (pick < 75) begin
        send_piece(chance(80), num, chance(50) ? 2'b10 : 2'b00);
      end else if (pick < 85) begin
        send_frame(pick_dst(1'b1), pick_src(1'b1), FRAME_TYPE, 16'd4, num, 2'b11, 4,
                   $urandom_range(1, 23));
      end else begin
        send_piece(1'b0, num, 2'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct  = 38;
    out_idle_pct = 59;
    set_config(rand48(), rand48(), 1'b0);

    // single pieces: own address, then broadcast with excess payload
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd2, 16'd7, 2'b11, 2, 0);
    send_frame(BCAST48, dev_addr, FRAME_TYPE, 16'd1, 16'd7, 2'b11, 3, 0);
    // rejections: type, destination, source
    send_frame(host_addr, dev_addr, FRAME_TYPE ^ 16'h0001, 16'd2, 16'd0, 2'b11, 2, 0);
    send_frame(host_addr ^ 48'd1, dev_addr, FRAME_TYPE, 16'd2, 16'd0, 2'b11, 2, 0);
    send_frame(host_addr, ~dev_addr, FRAME_TYPE, 16'd2, 16'd0, 2'b11, 2, 0);
    // first, middle, then a new first over an open reassembly
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd2, 16'h1234, 2'b01, 2, 0);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd1, 16'h1234, 2'b00, 1, 0);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd1, 16'hFFFF, 2'b01, 1, 0);
    // middle with the wrong number, last with nothing open
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd1, 16'h0000, 2'b00, 1, 0);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd1, 16'h0000, 2'b10, 1, 0);
    // matching first and last releases
    send_frame(BCAST48, dev_addr, FRAME_TYPE, 16'd2, 16'hABCD, 2'b01, 2, 0);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd2, 16'hABCD, 2'b10, 2, 0);
    // short frames, header end on the last byte, payload short of its size
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd2, 16'd0, 2'b11, 2, 1);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'd2, 16'd0, 2'b11, 2, 23);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'hFFFF, 16'd0, 2'b11, 0, 0);
    send_frame(host_addr, dev_addr, FRAME_TYPE, 16'h8000, 16'd0, 2'b11, 3, 0);
    wait_drain();

    // sender idles less than receiver; long receiver hold-off midway
    run_traffic(90);
    hold_asked++;
    run_traffic(80);
    wait_drain();

    // roles swapped; host equals broadcast, any source accepted
    in_idle_pct  = 59;
    out_idle_pct = 38;
    set_config(BCAST48, 48'd0, 1'b1);
    run_traffic(160);
    wait_drain();

    // full rate with a drain pause partway
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(48'd0, BCAST48, 1'b0);
    run_traffic(70);
    wait_drain();
    set_config(rand48(), rand48(), 1'b0);
    run_traffic(70);
    wait_drain();

    if (steer_chk.mismatches == 0 && steer_chk.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
